### rtl/mma_pkg.sv
`default_nettype none

package mma_pkg;

  // exponent bits used by power requests
  localparam int unsigned EXP_BITS = 64;

  // field and datapath widths
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned OPND_W     = 31;
  localparam int unsigned MOD_W      = 30;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PLAIN_W    = 64;
  localparam int unsigned EXPIN_W    = 64;
  localparam int unsigned CNT_W      = $clog2(PLAIN_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // input beat layout, lowest bit first
  localparam int unsigned A_LSB      = 0;
  localparam int unsigned B_LSB      = A_LSB + OPND_W;
  localparam int unsigned EXP_LSB    = B_LSB + OPND_W;
  localparam int unsigned PV_LSB     = EXP_LSB + EXPIN_W;
  localparam int unsigned IN_USED_W  = PV_LSB + PLAIN_W;
  localparam int unsigned IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OPND_W + 1 + 7) / 8) * 8;

  // register reset values
  localparam logic [MOD_W-1:0]  MODULUS_RST  = MOD_W'(3);
  localparam logic [WORD_W-1:0] NEG_INV_RST  = WORD_W'(32'h5555_5555);
  localparam logic [MOD_W-1:0]  R_SQUARED_RST = MOD_W'(1);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 4'd0,
    REQ_SUB   = 4'd1,
    REQ_MUL   = 4'd2,
    REQ_DIV   = 4'd3,
    REQ_POW   = 4'd4,
    REQ_NEG   = 4'd5,
    REQ_TO    = 4'd6,
    REQ_FROM  = 4'd7,
    REQ_EQUAL = 4'd8
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_NEG_INV   = 2'd1,
    CFG_R_SQUARED = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

### rtl/montgomery_modular_alu.sv
// to form reduces the plain value mod p, one remainder bit per cycle over 64 bits;
// pow runs square-and-multiply up to the highest set exponent bit; div runs as pow with
// exponent p-2, then one more product. all multiplies share one 32x32 multiplier.
// one request at a time; no new beat until done.
// reset (synchronous, active low) loads modulus 3, neg_inverse 0x55555555, r_squared 1.
`default_nettype none

module montgomery_modular_alu
  import mma_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // operand_a, operand_b, exponent, plain_value
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // result_value, is_equal
  // configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ALU, S_REM, S_TOF, S_MM, S_POW_INIT, S_POW_CHK,
    S_POW_ACC, S_POW_SQ, S_POW_SQD, S_CANON, S_FIN
  } state_t;

  state_t                state_r, ret_r;
  req_t                  op_r;
  logic [MOD_W-1:0]      modulus_r, r_squared_r;
  logic [WORD_W-1:0]     neg_inv_r;
  logic [OPND_W-1:0]     a_r, b_r;
  logic [WORD_W-1:0]     x_r, y_r, acc_r, sq_r, res_r;
  logic                  eq_r;
  logic [EXP_BITS-1:0]   exp_r;
  logic [PLAIN_W-1:0]    mag_r;
  logic                  neg_r;
  logic [MOD_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [1:0]            phase_r;
  logic [2*WORD_W-1:0]   prod_r, t_r;
  logic                  out_valid_r, out_eq_r;
  logic [OPND_W-1:0]     out_value_r;

  logic [WORD_W-1:0]     p_w, two_p, a_w, b_w, alu_raw, alu_fix, canon_a, canon_b;
  logic [WORD_W-1:0]     canon_res, one_seed, tof_val;
  logic [WORD_W-1:0]     mul_a, mul_b, mm_res;
  logic [2*WORD_W-1:0]   mul_p, mm_sum;
  logic [MOD_W:0]        rem_shift, rem_diff;
  logic [MOD_W-1:0]      rem_next, rem_eff, fe;
  logic [PLAIN_W-1:0]    fe_wide, in_plain, in_mag;
  logic [OPND_W-1:0]     in_a, in_b;
  logic [EXPIN_W-1:0]    in_exp;
  logic                  mod_ge2;

  // input beat fields
  assign in_a     = in_tdata[A_LSB +: OPND_W];
  assign in_b     = in_tdata[B_LSB +: OPND_W];
  assign in_exp   = in_tdata[EXP_LSB +: EXPIN_W];
  assign in_plain = in_tdata[PV_LSB +: PLAIN_W];
  assign in_mag   = in_plain[PLAIN_W-1] ? (~in_plain + PLAIN_W'(1)) : in_plain;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_eq_r, out_value_r};

  // modulus derived values
  assign p_w      = {{(WORD_W-MOD_W){1'b0}}, modulus_r};
  assign two_p    = {{(WORD_W-MOD_W-1){1'b0}}, modulus_r, 1'b0};
  assign mod_ge2  = (modulus_r >= MOD_W'(2));
  assign one_seed = p_w + (mod_ge2 ? WORD_W'(1) : WORD_W'(0));
  assign fe       = mod_ge2 ? (modulus_r - MOD_W'(2)) : '0;
  assign fe_wide  = {{(PLAIN_W-MOD_W){1'b0}}, fe};

  // add, sub, negate with 2p correction; equality on canonical values
  assign a_w = {1'b0, a_r};
  assign b_w = {1'b0, b_r};
  always_comb begin
    unique case (op_r)
      REQ_ADD: alu_raw = a_w + b_w - two_p;
      REQ_SUB: alu_raw = a_w - b_w;
      REQ_NEG: alu_raw = '0 - a_w;
      default: alu_raw = '0;
    endcase
  end
  assign alu_fix   = alu_raw[WORD_W-1] ? (alu_raw + two_p) : alu_raw;
  assign canon_a   = (a_w >= p_w) ? (a_w - p_w) : a_w;
  assign canon_b   = (b_w >= p_w) ? (b_w - p_w) : b_w;
  assign canon_res = (res_r >= p_w) ? (res_r - p_w) : res_r;

  // shared multiplier: product, then m = t*ninv, then m*p
  always_comb begin
    unique case (phase_r)
      2'd0: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      2'd1: begin
        mul_a = prod_r[WORD_W-1:0];
        mul_b = neg_inv_r;
      end
      2'd2: begin
        mul_a = prod_r[WORD_W-1:0];
        mul_b = p_w;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
  end
  assign mul_p  = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
  assign mm_sum = t_r + prod_r;
  assign mm_res = mm_sum[2*WORD_W-1:WORD_W];

  // restoring remainder step, one magnitude bit per cycle
  assign rem_shift = {rem_r, mag_r[PLAIN_W-1]};
  assign rem_diff  = rem_shift - {1'b0, modulus_r};
  assign rem_next  = (rem_shift >= {1'b0, modulus_r}) ? rem_diff[MOD_W-1:0]
                                                      : rem_shift[MOD_W-1:0];
  assign rem_eff   = (modulus_r == '0) ? '0 : rem_r;
  assign tof_val   = neg_r ? (p_w - {{(WORD_W-MOD_W){1'b0}}, rem_eff})
                           : (p_w + {{(WORD_W-MOD_W){1'b0}}, rem_eff});

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RST;
      neg_inv_r   <= NEG_INV_RST;
      r_squared_r <= R_SQUARED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODULUS:   modulus_r   <= cfg_wdata[MOD_W-1:0];
        CFG_NEG_INV:   neg_inv_r   <= cfg_wdata[WORD_W-1:0];
        CFG_R_SQUARED: r_squared_r <= cfg_wdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      // result beat taken; a finishing request reloads it below
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r  <= req_t'(in_tuser);
            a_r   <= in_a;
            b_r   <= in_b;
            eq_r  <= 1'b0;
            mag_r <= in_mag;
            neg_r <= in_plain[PLAIN_W-1];
            rem_r <= '0;
            cnt_r <= '0;
            unique case (req_t'(in_tuser))
              REQ_MUL: begin
                x_r     <= {1'b0, in_a};
                y_r     <= {1'b0, in_b};
                ret_r   <= S_FIN;
                state_r <= S_MM;
              end
              REQ_FROM: begin
                x_r     <= {1'b0, in_a};
                y_r     <= WORD_W'(1);
                ret_r   <= S_CANON;
                state_r <= S_MM;
              end
              REQ_POW: begin
                sq_r    <= {1'b0, in_a};
                exp_r   <= in_exp[EXP_BITS-1:0];
                x_r     <= one_seed;
                y_r     <= {{(WORD_W-MOD_W){1'b0}}, r_squared_r};
                ret_r   <= S_POW_INIT;
                state_r <= S_MM;
              end
              REQ_DIV: begin
                sq_r    <= {1'b0, in_b};
                exp_r   <= fe_wide[EXP_BITS-1:0];
                x_r     <= one_seed;
                y_r     <= {{(WORD_W-MOD_W){1'b0}}, r_squared_r};
                ret_r   <= S_POW_INIT;
                state_r <= S_MM;
              end
              REQ_TO:  state_r <= S_REM;
              default: state_r <= S_ALU;
            endcase
          end
        end
        // add, sub, negate and equality ops
        S_ALU: begin
          unique case (op_r)
            REQ_ADD, REQ_SUB, REQ_NEG: res_r <= alu_fix;
            REQ_EQUAL: begin
              res_r <= '0;
              eq_r  <= (canon_a == canon_b);
            end
            default: res_r <= '0;
          endcase
          state_r <= S_FIN;
        end
        // plain value magnitude mod p
        S_REM: begin
          rem_r <= rem_next;
          mag_r <= mag_r << 1;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(PLAIN_W - 1)) begin
            state_r <= S_TOF;
          end
        end
        S_TOF: begin
          x_r     <= tof_val;
          y_r     <= {{(WORD_W-MOD_W){1'b0}}, r_squared_r};
          ret_r   <= S_FIN;
          state_r <= S_MM;
        end
        // montgomery product, four phases
        S_MM: begin
          unique case (phase_r)
            2'd0: phase_r <= 2'd1;
            2'd1: begin
              t_r     <= prod_r;
              phase_r <= 2'd2;
            end
            2'd2: phase_r <= 2'd3;
            default: begin
              res_r   <= mm_res;
              phase_r <= 2'd0;
              state_r <= ret_r;
            end
          endcase
        end
        S_POW_INIT: begin
          acc_r   <= res_r;
          state_r <= S_POW_CHK;
        end
        // square-and-multiply round, stops after the highest set bit
        S_POW_CHK: begin
          if (exp_r == '0) begin
            if (op_r == REQ_DIV) begin
              x_r     <= a_w;
              y_r     <= acc_r;
              ret_r   <= S_FIN;
              state_r <= S_MM;
            end else begin
              res_r   <= acc_r;
              state_r <= S_FIN;
            end
          end else if (exp_r[0]) begin
            x_r     <= acc_r;
            y_r     <= sq_r;
            ret_r   <= S_POW_ACC;
            state_r <= S_MM;
          end else begin
            state_r <= S_POW_SQ;
          end
        end
        S_POW_ACC: begin
          acc_r   <= res_r;
          state_r <= S_POW_SQ;
        end
        S_POW_SQ: begin
          if ((exp_r >> 1) != '0) begin
            x_r     <= sq_r;
            y_r     <= sq_r;
            ret_r   <= S_POW_SQD;
            state_r <= S_MM;
          end else begin
            exp_r   <= exp_r >> 1;
            state_r <= S_POW_CHK;
          end
        end
        S_POW_SQD: begin
          sq_r    <= res_r;
          exp_r   <= exp_r >> 1;
          state_r <= S_POW_CHK;
        end
        S_CANON: begin
          res_r   <= canon_res;
          state_r <= S_FIN;
        end
        // hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_r[OPND_W-1:0];
            out_eq_r    <= eq_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
